[rtl/bsci_pkg.sv]
package bsci_pkg;

  localparam int ROW_WORDS  = 16;
  localparam int MAX_PLANES = 9;
  localparam int MAX_KEYS   = 256;

  localparam int WORD_BITS = 64;
  localparam int KEY_W     = 32;
  localparam int WIDX_W    = $clog2(ROW_WORDS);
  localparam int PSEL_W    = 4;
  localparam int KADDR_W   = $clog2(MAX_KEYS);
  localparam int KCNT_W    = 9;
  localparam int ROW_W     = 10;
  localparam int BIT_W     = $clog2(WORD_BITS);

  typedef logic [MAX_PLANES-1:0][WORD_BITS-1:0] plane_row_t;

  typedef struct packed {
    logic                 en;
    logic [PSEL_W-1:0]    plane;
    logic [WIDX_W-1:0]    word;
    logic [WORD_BITS-1:0] data;
  } plane_wr_t;

  typedef enum logic [1:0] {
    OP_LOAD_PLANE = 2'd0,
    OP_LOAD_KEY   = 2'd1,
    OP_ACCESS     = 2'd2,
    OP_SEEK       = 2'd3
  } opcode_t;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_KEY_COUNT = 1'b1;

  // plane d is in use when key_count >= 2**d; plane 0 always
  function automatic logic [MAX_PLANES-1:0] plane_mask(input logic [KCNT_W-1:0] kc);
    logic [MAX_PLANES-1:0] m;
    for (int d = 0; d < MAX_PLANES; d++) begin
      m[d] = (d == 0) || ((kc >> d) != '0);
    end
    return m;
  endfunction

endpackage

[rtl/bsci_plane_mem.sv]
module bsci_plane_mem (
  input  logic                  clk,
  input  bsci_pkg::plane_wr_t   wr,
  input  logic                  rd_en,
  input  logic [bsci_pkg::WIDX_W-1:0] rd_word,
  output bsci_pkg::plane_row_t  rd_data
);

  bsci_pkg::plane_row_t mem [bsci_pkg::ROW_WORDS];
  bsci_pkg::plane_row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.plane < bsci_pkg::PSEL_W'(bsci_pkg::MAX_PLANES))) begin
      mem[wr.word][wr.plane] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_word];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bit_sliced_column_index_unit.sv]
// Loads produce no word.
// Access: plane-row read, then key-table read, then the registered output word.
// Seek: search steps at the key-table read port (at most 9), then one output
//   word per cycle unless stalled (plane-row read port), row_count/64+1 words.
// A new item is taken only once the previous one has issued all its words.
// Synchronous active-low reset clears control and both config registers.
module bit_sliced_column_index_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_plane_select,
  input  logic [3:0]  in_word_select,
  input  logic [63:0] in_plane_bits,
  input  logic [7:0]  in_key_slot,
  input  logic signed [31:0] in_key_value,
  input  logic [9:0]  in_row_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_row_value,
  output logic [63:0] out_match_bits,
  output logic [3:0]  out_result_word,
  output logic        out_value_found,
  output logic        out_last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ACC_P = 5'b00010,
    ST_ACC_K = 5'b00100,
    ST_SRCH  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [bsci_pkg::ROW_W-1:0]  row_cnt_r;
  logic [bsci_pkg::KCNT_W-1:0] key_cnt_r;

  logic [bsci_pkg::KCNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [bsci_pkg::KADDR_W-1:0] mid_r, mid_nxt;
  logic signed [bsci_pkg::KEY_W-1:0] target_r, target_nxt;
  logic                         found_r, found_nxt;
  logic [bsci_pkg::MAX_PLANES-1:0] sel_idx_r, sel_idx_nxt;
  logic [bsci_pkg::WIDX_W-1:0]  w_r, w_nxt, last_w_r, last_w_nxt;
  logic [bsci_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic                         idx_hi_r, idx_hi_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [31:0]           out_row_value_r, out_row_value_nxt;
  logic [63:0]                  out_match_bits_r, out_match_bits_nxt;
  logic [3:0]                   out_result_word_r, out_result_word_nxt;
  logic                         out_value_found_r, out_value_found_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [bsci_pkg::KEY_W-1:0]   key_mem [bsci_pkg::MAX_KEYS];
  logic [bsci_pkg::KEY_W-1:0]   key_rd_r;
  logic                         key_we, key_rd_en;
  logic [bsci_pkg::KADDR_W-1:0] key_rd_addr;

  bsci_pkg::plane_wr_t          plane_wr;
  logic                         plane_rd_en;
  logic [bsci_pkg::WIDX_W-1:0]  plane_rd_word;
  bsci_pkg::plane_row_t         plane_rd;

  logic                         in_acc, out_free;
  logic [bsci_pkg::MAX_PLANES-1:0] mask;
  logic [bsci_pkg::MAX_PLANES-1:0] acc_idx;
  logic [63:0]                  match_word;
  logic [bsci_pkg::KCNT_W-1:0]  keys;
  logic [bsci_pkg::KCNT_W-1:0]  srch_lo, srch_hi;
  logic [bsci_pkg::KCNT_W:0]    srch_sum;

  bsci_plane_mem u_plane_mem (
    .clk     (clk),
    .wr      (plane_wr),
    .rd_en   (plane_rd_en),
    .rd_word (plane_rd_word),
    .rd_data (plane_rd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign mask      = bsci_pkg::plane_mask(key_cnt_r);
  assign keys      = (key_cnt_r > bsci_pkg::KCNT_W'(bsci_pkg::MAX_KEYS)) ?
                     bsci_pkg::KCNT_W'(bsci_pkg::MAX_KEYS) : key_cnt_r;

  always_comb begin
    for (int d = 0; d < bsci_pkg::MAX_PLANES; d++) begin
      acc_idx[d] = mask[d] & plane_rd[d][bit_r];
    end
  end

  always_comb begin
    match_word = '1;
    for (int d = 0; d < bsci_pkg::MAX_PLANES; d++) begin
      if (mask[d]) begin
        match_word = match_word & (sel_idx_r[d] ? plane_rd[d] : ~plane_rd[d]);
      end
    end
  end

  // next search bounds from the key read for mid_r
  always_comb begin
    srch_lo = lo_r;
    srch_hi = hi_r;
    if ($signed(key_rd_r) < target_r) begin
      srch_lo = {1'b0, mid_r} + bsci_pkg::KCNT_W'(1);
    end else begin
      srch_hi = {1'b0, mid_r};
    end
    srch_sum = {1'b0, srch_lo} + {1'b0, srch_hi};
  end

  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    target_nxt  = target_r;
    found_nxt   = found_r;
    sel_idx_nxt = sel_idx_r;
    w_nxt       = w_r;
    last_w_nxt  = last_w_r;
    bit_nxt     = bit_r;
    idx_hi_nxt  = idx_hi_r;

    out_valid_nxt       = out_valid_r && out_stall;
    out_row_value_nxt   = out_row_value_r;
    out_match_bits_nxt  = out_match_bits_r;
    out_result_word_nxt = out_result_word_r;
    out_value_found_nxt = out_value_found_r;
    out_last_nxt        = out_last_r;

    plane_wr       = '0;
    plane_rd_en    = 1'b0;
    plane_rd_word  = '0;
    key_we         = 1'b0;
    key_rd_en      = 1'b0;
    key_rd_addr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (bsci_pkg::opcode_t'(in_opcode))
            bsci_pkg::OP_LOAD_PLANE: begin
              plane_wr.en    = 1'b1;
              plane_wr.plane = in_plane_select;
              plane_wr.word  = in_word_select;
              plane_wr.data  = in_plane_bits;
            end
            bsci_pkg::OP_LOAD_KEY: begin
              key_we = 1'b1;
            end
            bsci_pkg::OP_ACCESS: begin
              plane_rd_en   = 1'b1;
              plane_rd_word = in_row_index[bsci_pkg::ROW_W-1:bsci_pkg::BIT_W];
              w_nxt         = in_row_index[bsci_pkg::ROW_W-1:bsci_pkg::BIT_W];
              bit_nxt       = in_row_index[bsci_pkg::BIT_W-1:0];
              state_nxt     = ST_ACC_P;
            end
            bsci_pkg::OP_SEEK: begin
              target_nxt  = in_key_value;
              last_w_nxt  = row_cnt_r[bsci_pkg::ROW_W-1:bsci_pkg::BIT_W];
              w_nxt       = '0;
              found_nxt   = 1'b0;
              sel_idx_nxt = '0;
              lo_nxt      = '0;
              hi_nxt      = keys;
              if (keys != '0) begin
                mid_nxt     = keys[bsci_pkg::KCNT_W-1:1];
                key_rd_en   = 1'b1;
                key_rd_addr = keys[bsci_pkg::KCNT_W-1:1];
                state_nxt   = ST_SRCH;
              end else begin
                plane_rd_en   = 1'b1;
                plane_rd_word = '0;
                state_nxt     = ST_EMIT;
              end
            end
          endcase
        end
      end
      ST_ACC_P: begin
        key_rd_en   = 1'b1;
        key_rd_addr = acc_idx[bsci_pkg::KADDR_W-1:0];
        idx_hi_nxt  = (acc_idx >> bsci_pkg::KADDR_W) != '0;
        state_nxt   = ST_ACC_K;
      end
      ST_ACC_K: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_row_value_nxt   = idx_hi_r ? '0 : $signed(key_rd_r);
          out_match_bits_nxt  = '0;
          out_result_word_nxt = w_r;
          out_value_found_nxt = 1'b0;
          out_last_nxt        = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      ST_SRCH: begin
        if ($signed(key_rd_r) == target_r) begin
          found_nxt     = 1'b1;
          sel_idx_nxt   = bsci_pkg::MAX_PLANES'(mid_r);
          plane_rd_en   = 1'b1;
          plane_rd_word = '0;
          state_nxt     = ST_EMIT;
        end else if (srch_lo < srch_hi) begin
          lo_nxt      = srch_lo;
          hi_nxt      = srch_hi;
          mid_nxt     = srch_sum[bsci_pkg::KADDR_W:1];
          key_rd_en   = 1'b1;
          key_rd_addr = srch_sum[bsci_pkg::KADDR_W:1];
        end else begin
          lo_nxt        = srch_lo;
          hi_nxt        = srch_hi;
          plane_rd_en   = 1'b1;
          plane_rd_word = '0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_row_value_nxt   = '0;
          out_match_bits_nxt  = found_r ? match_word : '0;
          out_result_word_nxt = w_r;
          out_value_found_nxt = found_r;
          out_last_nxt        = (w_r == last_w_r);
          if (w_r == last_w_r) begin
            state_nxt = ST_IDLE;
          end else begin
            w_nxt         = w_r + bsci_pkg::WIDX_W'(1);
            plane_rd_en   = 1'b1;
            plane_rd_word = w_r + bsci_pkg::WIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_cnt_r   <= '0;
      key_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bsci_pkg::CFG_ROW_COUNT: row_cnt_r <= cfg_wdata;
          bsci_pkg::CFG_KEY_COUNT: key_cnt_r <= cfg_wdata[bsci_pkg::KCNT_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r              <= lo_nxt;
    hi_r              <= hi_nxt;
    mid_r             <= mid_nxt;
    target_r          <= target_nxt;
    found_r           <= found_nxt;
    sel_idx_r         <= sel_idx_nxt;
    w_r               <= w_nxt;
    last_w_r          <= last_w_nxt;
    bit_r             <= bit_nxt;
    idx_hi_r          <= idx_hi_nxt;
    out_row_value_r   <= out_row_value_nxt;
    out_match_bits_r  <= out_match_bits_nxt;
    out_result_word_r <= out_result_word_nxt;
    out_value_found_r <= out_value_found_nxt;
    out_last_r        <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[in_key_slot] <= in_key_value;
    end
    if (key_rd_en) begin
      key_rd_r <= key_mem[key_rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_value   = out_row_value_r;
  assign out_match_bits  = out_match_bits_r;
  assign out_result_word = out_result_word_r;
  assign out_value_found = out_value_found_r;
  assign out_last        = out_last_r;

  a_match_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_found || (out_match_bits == '0)))
    else $error("match word set without a found value");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (lo_r < hi_r))
    else $error("search running on an empty range");

  a_emit_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && out_free |=> out_valid)
    else $error("seek word dropped");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

[tb/tb_bit_sliced_column_index_unit.sv]
module tb_bit_sliced_column_index_unit;
  import bsci_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    opcode_t                 opcode;
    logic [PSEL_W-1:0]       plane_select;
    logic [WIDX_W-1:0]       word_select;
    logic [WORD_BITS-1:0]    plane_bits;
    logic [KADDR_W-1:0]      key_slot;
    logic signed [KEY_W-1:0] key_value;
    logic [ROW_W-1:0]        row_index;
  } index_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] row_value;
    logic [WORD_BITS-1:0]    match_bits;
    logic [WIDX_W-1:0]       result_word;
    logic                    value_found;
    logic                    last;
  } reply_word_t;

  class column_lookup_model;
    logic [WORD_BITS-1:0]    plane_mem [MAX_PLANES*ROW_WORDS];
    bit                      plane_set [MAX_PLANES*ROW_WORDS];
    logic signed [KEY_W-1:0] keys_mem [MAX_KEYS];
    bit                      key_set [MAX_KEYS];
    int unsigned             rows_reg;
    int unsigned             keys_reg;
    reply_word_t             due_replies [$];
    int                      errors;

    function void set_reg(logic index, int unsigned value);
      if (index == CFG_ROW_COUNT) rows_reg = value & 10'h3FF;
      else keys_reg = value & 9'h1FF;
    endfunction

    function int active_planes();
      int unsigned v;
      int n;
      v = keys_reg;
      n = 1;
      while (v > 1) begin
        v = v >> 1;
        n++;
      end
      return (n > MAX_PLANES) ? MAX_PLANES : n;
    endfunction

    function int words_out();
      int n;
      n = (rows_reg >> 6) + 1;
      return (n > ROW_WORDS) ? ROW_WORDS : n;
    endfunction

    function int gather(logic [ROW_W-1:0] row, output int gap);
      int w, idx, e;
      w = row >> 6;
      idx = 0;
      gap = -1;
      for (int d = 0; d < active_planes(); d++) begin
        e = d * ROW_WORDS + w;
        if (!plane_set[e]) gap = e;
        else if (plane_mem[e][row[5:0]]) idx |= 1 << d;
      end
      return idx;
    endfunction

    function bit locate(logic signed [KEY_W-1:0] v, output int idx, output int gap);
      int lo, hi, mid;
      lo = 0;
      hi = (keys_reg > MAX_KEYS) ? MAX_KEYS : keys_reg;
      idx = 0;
      gap = -1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (!key_set[mid]) begin
          gap = mid;
          return 1'b0;
        end
        if (keys_mem[mid] < v) lo = mid + 1;
        else if (keys_mem[mid] > v) hi = mid;
        else begin
          idx = mid;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit find_gap(index_word_t it, output bit is_key, output int where);
      int idx, gap;
      bit hit;
      is_key = 1'b0;
      where = -1;
      if (it.opcode == OP_ACCESS) begin
        idx = gather(it.row_index, gap);
        if (gap >= 0) begin
          where = gap;
          return 1'b1;
        end
        if (idx < MAX_KEYS && !key_set[idx]) begin
          is_key = 1'b1;
          where = idx;
          return 1'b1;
        end
      end else if (it.opcode == OP_SEEK) begin
        hit = locate(it.key_value, idx, gap);
        if (gap >= 0) begin
          is_key = 1'b1;
          where = gap;
          return 1'b1;
        end
        if (hit) begin
          for (int w = 0; w < words_out(); w++) begin
            for (int d = 0; d < active_planes(); d++) begin
              if (!plane_set[d * ROW_WORDS + w]) begin
                where = d * ROW_WORDS + w;
                return 1'b1;
              end
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_input(index_word_t it);
      reply_word_t r;
      logic [WORD_BITS-1:0] m, p;
      int idx, gap, n;
      bit hit;
      case (it.opcode)
        OP_LOAD_PLANE: begin
          if (it.plane_select < MAX_PLANES) begin
            plane_mem[it.plane_select * ROW_WORDS + it.word_select] = it.plane_bits;
            plane_set[it.plane_select * ROW_WORDS + it.word_select] = 1'b1;
          end
        end
        OP_LOAD_KEY: begin
          keys_mem[it.key_slot] = it.key_value;
          key_set[it.key_slot] = 1'b1;
        end
        OP_ACCESS: begin
          idx = gather(it.row_index, gap);
          r.row_value = (idx < MAX_KEYS) ? keys_mem[idx] : '0;
          r.match_bits = '0;
          r.result_word = it.row_index[9:6];
          r.value_found = 1'b0;
          r.last = 1'b1;
          due_replies.push_back(r);
        end
        default: begin
          hit = locate(it.key_value, idx, gap);
          n = words_out();
          for (int w = 0; w < n; w++) begin
            m = hit ? '1 : '0;
            if (hit) begin
              for (int d = 0; d < active_planes(); d++) begin
                p = plane_mem[d * ROW_WORDS + w];
                m &= ((idx >> d) & 1) ? p : ~p;
              end
            end
            r.row_value = '0;
            r.match_bits = m;
            r.result_word = w[WIDX_W-1:0];
            r.value_found = hit;
            r.last = (w == n - 1);
            due_replies.push_back(r);
          end
        end
      endcase
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(reply_word_t got);
      reply_word_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("unexpected word, result_word %0d", got.result_word));
        return;
      end
      want = due_replies.pop_front();
      if (got.row_value !== want.row_value)
        report($sformatf("row_value got %0d want %0d", got.row_value, want.row_value));
      if (got.match_bits !== want.match_bits)
        report($sformatf("match_bits got %h want %h", got.match_bits, want.match_bits));
      if (got.result_word !== want.result_word)
        report($sformatf("result_word got %0d want %0d", got.result_word, want.result_word));
      if (got.value_found !== want.value_found)
        report($sformatf("value_found got %b want %b", got.value_found, want.value_found));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [9:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_opcode;
  logic [3:0] in_plane_select;
  logic [3:0] in_word_select;
  logic [63:0] in_plane_bits;
  logic [7:0] in_key_slot;
  logic signed [31:0] in_key_value;
  logic [9:0] in_row_index;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_row_value;
  logic [63:0] out_match_bits;
  logic [3:0] out_result_word;
  logic out_value_found;
  logic out_last;

  int send_gap_pct;
  int recv_hold_pct;
  column_lookup_model sb = new;

  bit_sliced_column_index_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_plane_select(in_plane_select),
    .in_word_select(in_word_select),
    .in_plane_bits(in_plane_bits),
    .in_key_slot(in_key_slot),
    .in_key_value(in_key_value),
    .in_row_index(in_row_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row_value(out_row_value),
    .out_match_bits(out_match_bits),
    .out_result_word(out_result_word),
    .out_value_found(out_value_found),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : result_monitor
    reply_word_t got;
    bit took;
    took = rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0;
    got = {out_row_value, out_match_bits, out_result_word, out_value_found, out_last};
    out_stall <= ($urandom_range(99) < recv_hold_pct);
    #1;
    if (took) sb.check(got);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("tb_bit_sliced_column_index_unit failed");
    $finish;
  end

  function automatic index_word_t any_word(opcode_t op);
    index_word_t it;
    it.opcode = op;
    it.plane_select = $urandom_range(15);
    it.word_select = $urandom_range(15);
    it.plane_bits = {$urandom, $urandom};
    it.key_slot = $urandom_range(255);
    it.key_value = $urandom;
    it.row_index = $urandom_range(1023);
    return it;
  endfunction

  function automatic index_word_t next_word();
    index_word_t it;
    int r, n, slot;
    it = any_word(OP_ACCESS);
    r = $urandom_range(99);
    n = (sb.keys_reg > MAX_KEYS) ? MAX_KEYS : sb.keys_reg;
    if (r < 40) begin
      if ($urandom_range(9) < 7) it.row_index = $urandom_range(sb.rows_reg, 0);
    end else if (r < 85) begin
      it.opcode = OP_SEEK;
      if (n > 0 && $urandom_range(9) < 7) begin
        slot = $urandom_range(n - 1, 0);
        if (sb.key_set[slot]) it.key_value = sb.keys_mem[slot];
        if ($urandom_range(3) == 0) it.key_value += ($urandom_range(1) ? 1 : -1);
      end
    end else if (r < 95) begin
      it.opcode = OP_LOAD_PLANE;
    end else begin
      it.opcode = OP_LOAD_KEY;
    end
    return it;
  endfunction

  task automatic send(index_word_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= it.opcode;
    in_plane_select <= it.plane_select;
    in_word_select  <= it.word_select;
    in_plane_bits   <= it.plane_bits;
    in_key_slot     <= it.key_slot;
    in_key_value    <= it.key_value;
    in_row_index    <= it.row_index;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic issue(index_word_t it);
    index_word_t fix;
    bit is_key;
    int where;
    while (sb.find_gap(it, is_key, where)) begin
      if (is_key) begin
        fix = any_word(OP_LOAD_KEY);
        fix.key_slot = where;
      end else begin
        fix = any_word(OP_LOAD_PLANE);
        fix.plane_select = where / ROW_WORDS;
        fix.word_select = where % ROW_WORDS;
      end
      send(fix);
    end
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_regs(int unsigned rc, int unsigned kc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= rc[9:0];
    @(posedge clk);
    sb.set_reg(CFG_ROW_COUNT, rc);
    cfg_index <= CFG_KEY_COUNT;
    cfg_wdata <= kc[9:0];
    @(posedge clk);
    sb.set_reg(CFG_KEY_COUNT, kc);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_keys(int n, bit extremes);
    index_word_t it;
    longint v;
    v = extremes ? -64'sd2147483648 :
        longint'($urandom_range(32'hF000_0000, 0)) - 64'sd2147483648;
    for (int k = 0; k < n; k++) begin
      it = any_word(OP_LOAD_KEY);
      it.key_slot = k;
      it.key_value = (extremes && k > 0 && k == n - 1) ? 32'sh7FFF_FFFF : v[31:0];
      send(it);
      v += ($urandom_range(3) == 0) ? 1 : $urandom_range(1 << 20, 2);
    end
  endtask

  task automatic load_planes(int n_planes, int n_words);
    logic [WORD_BITS-1:0] pw [MAX_PLANES];
    index_word_t it;
    int idx;
    for (int w = 0; w < n_words; w++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        idx = $urandom_range((1 << n_planes) - 1, 0);
        for (int d = 0; d < n_planes; d++) pw[d][i] = (idx >> d) & 1;
      end
      for (int d = 0; d < n_planes; d++) begin
        it = any_word(OP_LOAD_PLANE);
        it.plane_select = d;
        it.word_select = w;
        it.plane_bits = pw[d];
        send(it);
      end
    end
  endtask

  task automatic prepare(int unsigned rc, int unsigned kc, bit extremes);
    drain();
    repeat (8) @(posedge clk);
    set_regs(rc, kc);
    load_keys((kc > MAX_KEYS) ? MAX_KEYS : kc, extremes);
    load_planes(sb.active_planes(), sb.words_out());
  endtask

  task automatic mix(int n, int hold_at);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain();
      issue(next_word());
    end
  endtask

  initial begin : stimulus
    index_word_t it;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ROW_COUNT;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_LOAD_PLANE;
    in_plane_select <= '0;
    in_word_select  <= '0;
    in_plane_bits   <= '0;
    in_key_slot     <= '0;
    in_key_value    <= '0;
    in_row_index    <= '0;
    out_stall       <= 1'b0;
    send_gap_pct = 30;
    recv_hold_pct = 71;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    prepare(0, 0, 1'b0);
    it = any_word(OP_SEEK);
    it.key_value = '0;
    issue(it);
    it = any_word(OP_ACCESS);
    it.row_index = '0;
    issue(it);
    it = any_word(OP_LOAD_PLANE);
    it.plane_select = 4'hF;
    it.word_select = 4'hF;
    it.plane_bits = '1;
    issue(it);
    it = any_word(OP_LOAD_PLANE);
    it.plane_select = MAX_PLANES;
    it.plane_bits = '0;
    issue(it);
    it = any_word(OP_LOAD_PLANE);
    it.plane_select = 0;
    it.word_select = 4'hF;
    it.plane_bits = '1;
    issue(it);
    it = any_word(OP_LOAD_KEY);
    it.key_slot = 8'hFF;
    it.key_value = 32'sh8000_0000;
    issue(it);
    it = any_word(OP_ACCESS);
    it.row_index = 10'h3FF;
    issue(it);

    prepare(1023, 256, 1'b1);
    it = any_word(OP_SEEK);
    it.key_value = 32'sh8000_0000;
    issue(it);
    it.key_value = 32'sh7FFF_FFFF;
    issue(it);
    it.key_value = sb.keys_mem[128];
    issue(it);
    it.key_value = sb.keys_mem[128] + 1;
    issue(it);
    it.key_value = $urandom;
    issue(it);
    it = any_word(OP_ACCESS);
    it.row_index = 0;
    issue(it);
    it.row_index = 63;
    issue(it);
    it.row_index = 64;
    issue(it);
    it.row_index = 600;
    issue(it);
    it = any_word(OP_LOAD_PLANE);
    it.plane_select = MAX_PLANES - 1;
    it.word_select = 4'hF;
    it.plane_bits = '1;
    issue(it);
    it = any_word(OP_ACCESS);
    it.row_index = 10'h3FF;
    issue(it);

    prepare($urandom_range(127, 0), 1, 1'b0);
    mix(37, -1);
    prepare($urandom_range(255, 128), $urandom_range(31, 3), 1'b0);
    mix(37, 18);
    send_gap_pct = 71;
    recv_hold_pct = 30;
    prepare(1023, 255, 1'b0);
    mix(37, -1);
    prepare($urandom_range(300, 0), 2, 1'b0);
    mix(37, -1);
    send_gap_pct = 0;
    recv_hold_pct = 0;
    prepare($urandom_range(1023, 0), $urandom_range(64, 5), 1'b0);
    mix(37, -1);
    prepare(63, 0, 1'b0);
    mix(37, -1);

    drain();
    repeat (32) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_bit_sliced_column_index_unit passed");
    end else begin
      $display("tb_bit_sliced_column_index_unit failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/bsci_pkg.sv
rtl/bsci_plane_mem.sv
rtl/bit_sliced_column_index_unit.sv
tb/tb_bit_sliced_column_index_unit.sv
